### rtl/core/srctok_pkg.sv
// ----------------------------------------------------------------------------
// srctok_pkg
// Shared types, token codes, keyword table and character classes for the
// source tokenizer.
// ----------------------------------------------------------------------------
package srctok_pkg;

    // default sizes
    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 9;
    localparam int KW_MAX_CHARS      = 9;
    localparam int KW_COUNT          = 15;
    localparam int START_BITS        = 16;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    // scanner state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM
    } scan_mode_t;

    // token kinds
    localparam logic [5:0] KIND_LABEL     = 6'd0;
    localparam logic [5:0] KIND_NUMERIC   = 6'd1;
    localparam logic [5:0] KIND_IF        = 6'd2;
    localparam logic [5:0] KIND_ELSE      = 6'd3;
    localparam logic [5:0] KIND_STRUCT    = 6'd4;
    localparam logic [5:0] KIND_FOR       = 6'd5;
    localparam logic [5:0] KIND_WHILE     = 6'd6;
    localparam logic [5:0] KIND_COMP      = 6'd7;
    localparam logic [5:0] KIND_RETURN    = 6'd8;
    localparam logic [5:0] KIND_VOID      = 6'd9;
    localparam logic [5:0] KIND_FUNC      = 6'd10;
    localparam logic [5:0] KIND_LET       = 6'd11;
    localparam logic [5:0] KIND_CONST     = 6'd12;
    localparam logic [5:0] KIND_VAR       = 6'd13;
    localparam logic [5:0] KIND_ENUM      = 6'd14;
    localparam logic [5:0] KIND_LPAREN    = 6'd15;
    localparam logic [5:0] KIND_LANGLE    = 6'd16;
    localparam logic [5:0] KIND_LBRACKET  = 6'd17;
    localparam logic [5:0] KIND_LBRACE    = 6'd18;
    localparam logic [5:0] KIND_RPAREN    = 6'd19;
    localparam logic [5:0] KIND_RANGLE    = 6'd20;
    localparam logic [5:0] KIND_RBRACKET  = 6'd21;
    localparam logic [5:0] KIND_RBRACE    = 6'd22;
    localparam logic [5:0] KIND_ASSIGN    = 6'd23;
    localparam logic [5:0] KIND_DOT       = 6'd24;
    localparam logic [5:0] KIND_PLUS      = 6'd25;
    localparam logic [5:0] KIND_MINUS     = 6'd26;
    localparam logic [5:0] KIND_STAR      = 6'd27;
    localparam logic [5:0] KIND_SLASH     = 6'd28;
    localparam logic [5:0] KIND_BANG      = 6'd29;
    localparam logic [5:0] KIND_COMMA     = 6'd30;
    localparam logic [5:0] KIND_SEMICOLON = 6'd31;
    localparam logic [5:0] KIND_COLON     = 6'd32;
    localparam logic [5:0] KIND_ERROR     = 6'd33;

    // character codes used by name
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } byte_item_t;

    // output transaction
    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_in_run;
    } token_t;

    // tokens produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_result_t;

    // keyword table entry, text[0] is the first character
    typedef struct packed {
        logic [3:0]                         len;
        logic [0:KW_MAX_CHARS-1][7:0]       text;
        logic [5:0]                         kind;
    } kw_entry_t;

    localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
        '{4'd2, {"if",        56'h0}, KIND_IF},
        '{4'd4, {"else",      40'h0}, KIND_ELSE},
        '{4'd6, {"struct",    24'h0}, KIND_STRUCT},
        '{4'd3, {"for",       48'h0}, KIND_FOR},
        '{4'd5, {"while",     32'h0}, KIND_WHILE},
        '{4'd4, {"comp",      40'h0}, KIND_COMP},
        '{4'd6, {"return",    24'h0}, KIND_RETURN},
        '{4'd4, {"void",      40'h0}, KIND_VOID},
        '{4'd9, {"constexpr"},        KIND_VOID},
        '{4'd5, {"match",     32'h0}, KIND_VOID},
        '{4'd4, {"func",      40'h0}, KIND_FUNC},
        '{4'd3, {"let",       48'h0}, KIND_LET},
        '{4'd5, {"const",     32'h0}, KIND_CONST},
        '{4'd3, {"var",       48'h0}, KIND_VAR},
        '{4'd4, {"enum",      40'h0}, KIND_ENUM}
    };

    // a-z or A-Z
    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    // 0-9
    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // space, tab, CR, LF
    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
    endfunction

    // kind of a single-byte token, error for anything unknown
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] kind;
        case (c)
            8'h28:    kind = KIND_LPAREN;
            8'h3C:    kind = KIND_LANGLE;
            8'h5B:    kind = KIND_LBRACKET;
            8'h7B:    kind = KIND_LBRACE;
            8'h29:    kind = KIND_RPAREN;
            8'h3E:    kind = KIND_RANGLE;
            8'h5D:    kind = KIND_RBRACKET;
            8'h7D:    kind = KIND_RBRACE;
            8'h3D:    kind = KIND_ASSIGN;
            CHAR_DOT: kind = KIND_DOT;
            8'h2B:    kind = KIND_PLUS;
            8'h2D:    kind = KIND_MINUS;
            8'h2A:    kind = KIND_STAR;
            8'h2F:    kind = KIND_SLASH;
            8'h21:    kind = KIND_BANG;
            8'h2C:    kind = KIND_COMMA;
            8'h3B:    kind = KIND_SEMICOLON;
            8'h3A:    kind = KIND_COLON;
            default:  kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

endpackage

### rtl/core/srctok_stream_if.sv
// ----------------------------------------------------------------------------
// srctok_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface srctok_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

### rtl/core/srctok_kw_match.sv
// ----------------------------------------------------------------------------
// srctok_kw_match
// Compares a word prefix and its length against the keyword table and
// returns the keyword kind, or the label kind when nothing matches.
// ----------------------------------------------------------------------------
module srctok_kw_match
    import srctok_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic [KEYWORD_CHARS-1:0][7:0] prefix,
    input  logic [15:0]                   length,
    output logic [5:0]                    kind
);

    // all entries compared in parallel, lengths are exact so at most one hits
    always_comb
    begin
        logic hit;
        kind = KIND_LABEL;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit = (length == 16'(KW_TABLE[k].len));
            for (int i = 0; i < KW_MAX_CHARS; i++)
            begin
                if ((4'(i) < KW_TABLE[k].len) && (prefix[i] != KW_TABLE[k].text[i]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = KW_TABLE[k].kind;
            end
        end
    end

endmodule

### rtl/core/srctok_scan.sv
// ----------------------------------------------------------------------------
// srctok_scan
// Scanner state and token decisions for one byte: grows or closes the open
// word or number, emits single-byte tokens and flushes at end of input.
// ----------------------------------------------------------------------------
module srctok_scan
    import srctok_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  byte_item_t   item,
    output scan_result_t result
);

    localparam int IDX_BITS  = $clog2(KEYWORD_CHARS);
    localparam int START_USE = (POSITION_BITS < START_BITS) ? POSITION_BITS : START_BITS;

    scan_mode_t                     mode_reg, mode_next;
    logic [KEYWORD_CHARS-1:0][7:0]  prefix_reg, prefix_next;
    logic [15:0]                    open_len_reg, open_len_next;
    logic [POSITION_BITS-1:0]       open_start_reg, open_start_next;
    logic [POSITION_BITS-1:0]       pos_reg, pos_next;

    logic [7:0]                     c;
    logic                           letter, digit, alnum, space, cont;
    logic [15:0]                    len_grown;
    logic [KEYWORD_CHARS-1:0][7:0]  prefix_grown;
    logic [KEYWORD_CHARS-1:0][7:0]  kw_prefix;
    logic [15:0]                    kw_length;
    logic [5:0]                     word_kind;
    logic [15:0]                    start_open, start_here;
    logic                           emit_old, emit_single, emit_last;
    token_t                         tok_old, tok_single, tok_last;

    // byte classes
    assign c      = item.char_code;
    assign letter = is_letter(c);
    assign digit  = is_digit(c);
    assign alnum  = letter || digit;
    assign space  = is_space(c);
    assign cont   = ((mode_reg == MODE_WORD) && is_word_char(c))
                 || ((mode_reg == MODE_NUM) && (digit || (c == CHAR_DOT)));

    // open token grown by this byte
    assign len_grown = (open_len_reg == LEN_MAX) ? LEN_MAX : open_len_reg + 16'd1;

    always_comb
    begin
        prefix_grown = prefix_reg;
        if ((mode_reg == MODE_WORD) && (open_len_reg < 16'(KEYWORD_CHARS)))
        begin
            prefix_grown[open_len_reg[IDX_BITS-1:0]] = c;
        end
    end

    // keyword lookup on the word that gets closed this cycle
    assign kw_prefix = cont ? prefix_grown : prefix_reg;
    assign kw_length = cont ? len_grown : open_len_reg;

    srctok_kw_match #(
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_kw_match (
        .prefix (kw_prefix),
        .length (kw_length),
        .kind   (word_kind)
    );

    assign start_open = 16'(open_start_reg[START_USE-1:0]);
    assign start_here = 16'(pos_reg[START_USE-1:0]);

    // candidate tokens
    always_comb
    begin
        emit_old    = !cont && (mode_reg != MODE_IDLE);
        emit_single = !cont && !space && !alnum;
        emit_last   = item.end_of_input && (cont || alnum);

        tok_old.token_kind   = (mode_reg == MODE_WORD) ? word_kind : KIND_NUMERIC;
        tok_old.token_start  = start_open;
        tok_old.token_length = open_len_reg;
        tok_old.last_in_run  = 1'b0;

        tok_single.token_kind   = single_kind(c);
        tok_single.token_start  = start_here;
        tok_single.token_length = 16'd1;
        tok_single.last_in_run  = 1'b0;

        if (cont)
        begin
            tok_last.token_kind   = (mode_reg == MODE_WORD) ? word_kind : KIND_NUMERIC;
            tok_last.token_start  = start_open;
            tok_last.token_length = len_grown;
        end
        else
        begin
            // a one-byte word is never a keyword
            tok_last.token_kind   = letter ? KIND_LABEL : KIND_NUMERIC;
            tok_last.token_start  = start_here;
            tok_last.token_length = 16'd1;
        end
        tok_last.last_in_run = 1'b0;
    end

    // order the tokens and mark the last one
    always_comb
    begin
        result.count  = 2'(emit_old) + 2'(emit_single) + 2'(emit_last);
        result.first  = emit_old ? tok_old : (emit_single ? tok_single : tok_last);
        result.second = emit_single ? tok_single : tok_last;
        if (result.count == 2'd1)
        begin
            result.first.last_in_run = 1'b1;
        end
        if (result.count == 2'd2)
        begin
            result.second.last_in_run = 1'b1;
        end
    end

    // next scanner state
    always_comb
    begin
        mode_next       = mode_reg;
        prefix_next     = prefix_reg;
        open_len_next   = open_len_reg;
        open_start_next = open_start_reg;
        if (cont)
        begin
            open_len_next = len_grown;
            prefix_next   = prefix_grown;
        end
        else if (alnum)
        begin
            mode_next       = letter ? MODE_WORD : MODE_NUM;
            open_start_next = pos_reg;
            open_len_next   = 16'd1;
            prefix_next[0]  = c;
        end
        else
        begin
            mode_next = MODE_IDLE;
        end
        if (item.end_of_input)
        begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            open_len_reg   <= '0;
            open_start_reg <= '0;
            pos_reg        <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            open_len_reg   <= open_len_next;
            open_start_reg <= open_start_next;
            pos_reg        <= pos_next;
        end
    end

    // word prefix bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
        end
        else if (fire)
        begin
            prefix_reg <= prefix_next;
        end
    end

    // end of input starts a fresh text
    a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_input |=> (mode_reg == MODE_IDLE) && (pos_reg == '0))
        else $error("scanner not back at start after end of input");

    // an open token always holds at least one byte
    a_open_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (open_len_reg != 16'd0))
        else $error("open token with zero length");

    // only the final token of a pair carries the run mark
    a_run_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (result.count == 2'd2) |-> (!result.first.last_in_run && result.second.last_in_run))
        else $error("run mark on wrong token of a pair");

endmodule

### rtl/core/srctok_outq.sv
// ----------------------------------------------------------------------------
// srctok_outq
// Two-entry token queue that takes up to two tokens per cycle and drives
// the output stream one token per transaction.
// ----------------------------------------------------------------------------
module srctok_outq
    import srctok_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  scan_result_t           push,
    output logic [1:0]             space,
    srctok_stream_if.source        token_out
);

    token_t     q_reg [2];
    token_t     q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] kept, push_n;
    logic       pop;

    assign pop             = token_out.valid && token_out.ready;
    assign token_out.valid = (cnt_reg != 2'd0);
    assign token_out.data  = q_reg[0];

    // room for this cycle, counting the entry that leaves
    assign kept  = cnt_reg - 2'(pop);
    assign space = 2'd2 - kept;

    // shift out the head, append new tokens behind what stays
    always_comb
    begin
        push_n    = push_en ? push.count : 2'd0;
        q_next[0] = (kept == 2'd0) ? push.first : (pop ? q_reg[1] : q_reg[0]);
        if (kept == 2'd0)
        begin
            q_next[1] = push.second;
        end
        else if (kept == 2'd1)
        begin
            q_next[1] = push.first;
        end
        else
        begin
            q_next[1] = q_reg[1];
        end
        cnt_next = kept + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // the queue never holds more than two tokens
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("token queue overfilled");

    // the scanner only writes what fits
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (push.count <= space))
        else $error("tokens pushed without room");

    // pushed tokens show up on the output
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push_en && (push.count != 2'd0) |=> token_out.valid)
        else $error("pushed token not presented");

endmodule

### rtl/core/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-stream lexical analyzer producing kind/start/length tokens.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one source byte per transaction (char_code) with a flag
//   marking the last byte of a text (end_of_input). token_out carries one
//   token per transaction: kind, start position, saturating length, and a
//   mark on the last token caused by a given byte.
//   A byte taken from byte_in is held in the input register and scanned once
//   the token queue has room for all of its tokens; its tokens are then
//   registered in the queue and presented on token_out. One byte is taken
//   per cycle while the queue keeps room; a byte that causes two tokens
//   (a closed word or number plus a single-byte or flushed token) needs
//   two transactions on token_out, which carries one token per transaction.
//   Reset clears the scanner to idle with position zero and empties the
//   token queue. When token_out stalls, up to two tokens wait in the queue
//   and one more byte waits in the input register; byte_in then drops ready
//   until room is made. End of input flushes any open token and restarts
//   the position count at zero.
// ----------------------------------------------------------------------------
module source_tokenizer
    import srctok_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    srctok_stream_if.sink   byte_in,
    srctok_stream_if.source token_out
);

    logic         in_valid_reg, in_valid_next;
    byte_item_t   in_data_reg;
    logic         fire;
    logic         take;
    logic [1:0]   space;
    scan_result_t result;

    // scan a held byte once the queue has room for all of its tokens
    assign fire         = in_valid_reg && (result.count <= space);
    assign byte_in.ready = !in_valid_reg || fire;
    assign take         = byte_in.valid && byte_in.ready;

    // input register
    always_comb
    begin
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= byte_in.data;
        end
    end

    // scanner
    srctok_scan #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data_reg),
        .result (result)
    );

    // token queue and output stream
    srctok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (result),
        .space     (space),
        .token_out (token_out)
    );

endmodule
